// File: sv/trr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trr_pkg
// Shared types, constants and helpers of the translation RRIP replacement block.
// ----------------------------------------------------------------------------
package trr_pkg;

	localparam int SET_COUNT          = 128;
	localparam int WAY_COUNT          = 16;
	localparam int PAGE_TABLE_ENTRIES = 1024;

	localparam int SET_W  = $clog2(SET_COUNT);
	localparam int WAY_W  = $clog2(WAY_COUNT);
	localparam int PT_W   = $clog2(PAGE_TABLE_ENTRIES);
	localparam int RRPV_W = 4;
	localparam int CNT_W  = 7;
	localparam int PAGE_W = 52;
	localparam int TAG_W  = PAGE_W - PT_W;
	localparam int ROW_W  = WAY_COUNT * RRPV_W;
	localparam int PENT_W = 1 + TAG_W + CNT_W;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_MAX_RRPV  = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_INSTR_POS = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_DATA_POS  = REG_IDX_W'(2);

	localparam logic [RRPV_W-1:0] MAX_RRPV_RST  = RRPV_W'(7);
	localparam logic [RRPV_W-1:0] INSTR_POS_RST = RRPV_W'(1);
	localparam logic [RRPV_W-1:0] DATA_POS_RST  = RRPV_W'(1);

	localparam logic signed [CNT_W-1:0] COUNT_START = -7'sd2;
	localparam logic signed [CNT_W-1:0] COUNT_LIMIT = 7'sd50;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_VICTIM = 1'b1;

	localparam logic [PT_W-1:0]  PT_LAST  = PT_W'(PAGE_TABLE_ENTRIES - 1);
	localparam logic [WAY_W-1:0] WAY_LAST = WAY_W'(WAY_COUNT - 1);

	typedef logic [WAY_COUNT-1:0][RRPV_W-1:0] row_t;

	typedef struct packed {
		logic                     valid;
		logic [TAG_W-1:0]         tag;
		logic signed [CNT_W-1:0]  cnt;
	} pent_t;

	typedef struct packed {
		logic [RRPV_W-1:0] max_rrpv;
		logic [RRPV_W-1:0] instr_position;
		logic [RRPV_W-1:0] data_position;
	} cfg_t;

	typedef struct packed {
		logic              last;
		logic [WAY_W-1:0]  way;
		logic [RRPV_W-1:0] k;
	} scan_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE,
		ST_SCAN,
		ST_WRITE
	} state_t;

	function automatic logic [RRPV_W-1:0] sub_clamp(input logic [RRPV_W-1:0] a,
		input logic [RRPV_W-1:0] b);
		return (a > b) ? a - b : '0;
	endfunction

endpackage
`default_nettype wire

// File: sv/trr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module trr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: sv/trr_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trr_regs
// APB configuration registers: max_rrpv, instr_position, data_position.
// ----------------------------------------------------------------------------
module trr_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [trr_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [trr_pkg::APB_DATA_W-1:0]   pwdata,
	output      logic [trr_pkg::APB_DATA_W-1:0]   prdata,
	output      logic                             pready,
	output      trr_pkg::cfg_t                    cfg
);
	import trr_pkg::*;

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] idx;
	logic                 wr;

	assign idx    = paddr[APB_ADDR_W-1:2];
	assign wr     = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_rrpv       <= MAX_RRPV_RST;
			cfg_q.instr_position <= INSTR_POS_RST;
			cfg_q.data_position  <= DATA_POS_RST;
		end else if (wr) begin
			case (idx)
				REG_MAX_RRPV:  cfg_q.max_rrpv       <= pwdata[RRPV_W-1:0];
				REG_INSTR_POS: cfg_q.instr_position <= pwdata[RRPV_W-1:0];
				REG_DATA_POS:  cfg_q.data_position  <= pwdata[RRPV_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_MAX_RRPV:  prdata = APB_DATA_W'(cfg_q.max_rrpv);
			REG_INSTR_POS: prdata = APB_DATA_W'(cfg_q.instr_position);
			REG_DATA_POS:  prdata = APB_DATA_W'(cfg_q.data_position);
			default:       prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// File: sv/trr_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trr_scan
// Way scanner: one subtract and compare per cycle while run is high, tracks the smallest aging
// distance to max_rrpv and the lowest way that has it.
// ----------------------------------------------------------------------------
module trr_scan (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         run,
	input  wire trr_pkg::row_t                row,
	input  wire logic [trr_pkg::RRPV_W-1:0]   max_rrpv,
	output      trr_pkg::scan_t               res
);
	import trr_pkg::*;

	logic [WAY_W-1:0]  idx_q;
	logic [WAY_W-1:0]  pos_q;
	logic [RRPV_W-1:0] min_q;
	logic [RRPV_W-1:0] gap;
	logic              first;
	logic              last;

	assign gap   = max_rrpv - row[idx_q];
	assign first = (idx_q == '0);
	assign last  = (idx_q == WAY_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (run) begin
			idx_q <= last ? '0 : idx_q + WAY_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (run && (first || gap < min_q)) begin
			min_q <= gap;
			pos_q <= idx_q;
		end
	end

	assign res.last = last;
	assign res.way  = pos_q;
	assign res.k    = min_q;

endmodule
`default_nettype wire

// File: sv/translation_rrip_replacement.sv
`default_nettype none
// ----------------------------------------------------------------------------
// translation_rrip_replacement
// RRIP replacement state for a set-associative translation cache, with a
// tagged per-page access counter placing instruction translations.
// ----------------------------------------------------------------------------
// After reset the block clears the page counter table, one entry a cycle,
// over all PAGE_TABLE_ENTRIES (1024) entries; words are stalled meanwhile, while
// configuration writes are taken at once. For an update word the set row and
// page entry are read, then written back (the page entry for instruction words
// only). For a victim word one scanner compares one way per cycle to find the
// aging distance and the victim, then the aged row is written. A victim word
// returns one victim_way word; an update word returns none. Output is
// registered, so a new word may be taken while a result waits.
// ----------------------------------------------------------------------------
module translation_rrip_replacement (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [trr_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [trr_pkg::APB_DATA_W-1:0]    pwdata,
	output      logic [trr_pkg::APB_DATA_W-1:0]    prdata,
	output      logic                              pready,
	input  wire logic                              in_valid,
	output      logic                              in_stall,
	input  wire logic                              operation,
	input  wire logic [6:0]                        set_index,
	input  wire logic [3:0]                        way_index,
	input  wire logic                              hit,
	input  wire logic                              is_instruction,
	input  wire logic [trr_pkg::PAGE_W-1:0]        page_number,
	output      logic                              out_valid,
	input  wire logic                              out_stall,
	output      logic [3:0]                        victim_way
);
	import trr_pkg::*;

	cfg_t   cfg;
	scan_t  scan_res;
	state_t state_q, state_d;

	logic [PT_W-1:0]      clr_q;
	logic [SET_COUNT-1:0] row_valid_q;
	logic [SET_W-1:0]     set_q;
	logic [WAY_W-1:0]     way_q;
	logic                 way_ok_q;
	logic                 hit_q;
	logic                 instr_q;
	logic [TAG_W-1:0]     tag_q;
	logic [PT_W-1:0]      pidx_q;
	logic                 rv_q;
	logic                 out_valid_q;
	logic [3:0]           victim_q;

	logic                 accept;
	logic                 row_re, row_we, pg_re, pg_we, scan_run, out_load;
	logic [ROW_W-1:0]     row_rdata, row_wdata;
	logic [PENT_W-1:0]    pg_rdata, pg_wdata;
	logic [PT_W-1:0]      pg_waddr;

	row_t                 row_eff, row_upd, row_aged;
	pent_t                pent_rd, pent_new;
	logic                 pent_hit, cold;
	logic signed [CNT_W-1:0] cnt_cur;
	logic [RRPV_W-1:0]    new_rrpv;

	trr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	trr_ram #(.WIDTH(ROW_W), .DEPTH(SET_COUNT)) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (set_q),
		.wdata (row_wdata),
		.re    (row_re),
		.raddr (set_index[SET_W-1:0]),
		.rdata (row_rdata)
	);

	trr_ram #(.WIDTH(PENT_W), .DEPTH(PAGE_TABLE_ENTRIES)) u_page_ram (
		.clk   (clk),
		.we    (pg_we),
		.waddr (pg_waddr),
		.wdata (pg_wdata),
		.re    (pg_re),
		.raddr (page_number[PT_W-1:0]),
		.rdata (pg_rdata)
	);

	trr_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.run      (scan_run),
		.row      (row_eff),
		.max_rrpv (cfg.max_rrpv),
		.res      (scan_res)
	);

	assign accept = in_valid && !in_stall;

	// untouched rows read as zero
	assign row_eff = rv_q ? row_t'(row_rdata) : '0;
	assign pent_rd = pent_t'(pg_rdata);

	always_comb begin
		pent_hit = pent_rd.valid && (pent_rd.tag == tag_q);
		cnt_cur  = pent_hit ? pent_rd.cnt : COUNT_START;
		cold     = (cnt_cur < COUNT_LIMIT);
		pent_new.valid = 1'b1;
		pent_new.tag   = tag_q;
		pent_new.cnt   = cold ? cnt_cur + 7'sd1 : cnt_cur;
		if (instr_q) begin
			new_rrpv = cold ? sub_clamp(cfg.max_rrpv, cfg.instr_position) : '0;
		end else if (hit_q) begin
			new_rrpv = sub_clamp(cfg.max_rrpv, cfg.data_position);
		end else begin
			new_rrpv = sub_clamp(cfg.max_rrpv, RRPV_W'(1));
		end
		row_upd        = row_eff;
		row_upd[way_q] = new_rrpv;
		for (int w = 0; w < WAY_COUNT; w++) begin
			row_aged[w] = row_eff[w] + scan_res.k;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		row_re    = 1'b0;
		row_we    = 1'b0;
		row_wdata = row_upd;
		pg_re     = 1'b0;
		pg_we     = 1'b0;
		pg_waddr  = pidx_q;
		pg_wdata  = pent_new;
		scan_run  = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				pg_we    = 1'b1;
				pg_waddr = clr_q;
				pg_wdata = '0;
				if (clr_q == PT_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					row_re  = 1'b1;
					pg_re   = 1'b1;
					state_d = (operation == OP_VICTIM) ? ST_SCAN : ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				row_we  = way_ok_q;
				pg_we   = way_ok_q && instr_q;
				state_d = ST_IDLE;
			end
			ST_SCAN: begin
				scan_run = 1'b1;
				if (scan_res.last) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				row_wdata = row_aged;
				if (!(out_valid_q && out_stall)) begin
					row_we   = 1'b1;
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			row_valid_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + PT_W'(1);
			end
			if (row_we) begin
				row_valid_q[set_q] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			set_q    <= set_index[SET_W-1:0];
			way_q    <= WAY_W'(way_index);
			way_ok_q <= (int'(way_index) < WAY_COUNT);
			hit_q    <= hit;
			instr_q  <= is_instruction;
			tag_q    <= page_number[PAGE_W-1:PT_W];
			pidx_q   <= page_number[PT_W-1:0];
			rv_q     <= row_valid_q[set_index[SET_W-1:0]];
		end
		if (out_load) begin
			victim_q <= 4'(scan_res.way);
		end
	end

	assign out_valid  = out_valid_q;
	assign victim_way = victim_q;

`ifndef SYNTHESIS
	a_clear_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> in_stall && !row_we)
		else $error("word taken or row written during table clear");

	a_out_from_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_WRITE))
		else $error("result raised outside the write step");

	a_victim_reaches_max: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WRITE |->
			RRPV_W'(row_eff[scan_res.way] + scan_res.k) == cfg.max_rrpv)
		else $error("victim way does not reach max after aging");

	a_scan_only_victim: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |=> state_q == ST_SCAN || state_q == ST_WRITE)
		else $error("scan left without write-back");
`endif

endmodule
`default_nettype wire

// File: dv/translation_rrip_replacement_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// translation_rrip_replacement_test
// Self-checking bench for the translation RRIP replacement block. A scoreboard
// keeps its own copy of the per-way re-reference values, the tagged page
// counter table and the three settings. It works out the victim way of every
// accepted victim word and compares each returned victim_way with the oldest
// one it is waiting for. The run covers a directed opening, then phases of
// random words under several settings (extremes included), with random
// idling on both sides, a long output hold-off and a quiet final phase.
// ----------------------------------------------------------------------------
module translation_rrip_replacement_test;
	import trr_pkg::*;

	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 40;
	localparam int WATCHDOG      = 20000;
	localparam int PHASE_WORDS   = 150;
	localparam int PHASES        = 6;

	typedef struct {
		logic              op;
		logic [6:0]        set;
		logic [3:0]        way;
		logic              hit;
		logic              instr;
		logic [PAGE_W-1:0] page;
	} access_t;

	class victim_scoreboard;
		logic [RRPV_W-1:0]       max_rrpv;
		logic [RRPV_W-1:0]       instr_dist;
		logic [RRPV_W-1:0]       data_dist;
		logic [RRPV_W-1:0]       rrpv_mem [SET_COUNT][WAY_COUNT];
		logic signed [CNT_W-1:0] count_mem [PAGE_TABLE_ENTRIES];
		logic [TAG_W-1:0]        tag_mem [PAGE_TABLE_ENTRIES];
		bit                      live_mem [PAGE_TABLE_ENTRIES];
		logic [WAY_W-1:0]        pending_victims [$];
		int                      errors;

		function new();
			max_rrpv   = MAX_RRPV_RST;
			instr_dist = INSTR_POS_RST;
			data_dist  = DATA_POS_RST;
			errors     = 0;
			foreach (rrpv_mem[s, w]) rrpv_mem[s][w] = '0;
			foreach (live_mem[i]) live_mem[i] = 1'b0;
		endfunction

		function logic [RRPV_W-1:0] below_max(logic [RRPV_W-1:0] delta);
			return (max_rrpv > delta) ? max_rrpv - delta : '0;
		endfunction

		function void set_register(logic [REG_IDX_W-1:0] idx, logic [RRPV_W-1:0] val);
			case (idx)
				REG_MAX_RRPV:  max_rrpv   = val;
				REG_INSTR_POS: instr_dist = val;
				REG_DATA_POS:  data_dist  = val;
				default: ;
			endcase
		endfunction

		function void note_word(logic op, logic [6:0] set, logic [3:0] way, logic hit,
			logic instr, logic [PAGE_W-1:0] page);
			int                s;
			int                k;
			int                found;
			int                c;
			logic [RRPV_W-1:0] d;
			logic [PT_W-1:0]   idx;
			logic [TAG_W-1:0]  tag;
			s = set % SET_COUNT;
			if (op == OP_VICTIM) begin
				k = 16;
				for (int w = 0; w < WAY_COUNT; w++) begin
					d = max_rrpv - rrpv_mem[s][w];
					if (d < k) k = d;
				end
				found = 0;
				for (int w = WAY_COUNT - 1; w >= 0; w--) begin
					rrpv_mem[s][w] = rrpv_mem[s][w] + RRPV_W'(k);
					if (rrpv_mem[s][w] == max_rrpv) found = w;
				end
				pending_victims.insert(pending_victims.size(), WAY_W'(found));
				return;
			end
			if (way >= WAY_COUNT) return;
			if (!instr) begin
				rrpv_mem[s][way] = hit ? below_max(data_dist) : below_max(RRPV_W'(1));
				return;
			end
			idx = page[PT_W-1:0];
			tag = page[PAGE_W-1:PT_W];
			if (!live_mem[idx] || tag_mem[idx] != tag) begin
				live_mem[idx]  = 1'b1;
				tag_mem[idx]   = tag;
				count_mem[idx] = COUNT_START;
			end
			c = count_mem[idx];
			if (c < COUNT_LIMIT) begin
				rrpv_mem[s][way] = below_max(instr_dist);
				c++;
			end else begin
				rrpv_mem[s][way] = '0;
			end
			count_mem[idx] = CNT_W'(c);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40) $display("%0t: %s", $realtime, msg);
		endtask

		task check_word(logic [WAY_W-1:0] got);
			logic [WAY_W-1:0] want;
			if (pending_victims.size() == 0) begin
				report($sformatf("victim_way %0d with no victim word waiting", got));
			end else begin
				want = pending_victims.pop_front();
				if (got !== want)
					report($sformatf("victim_way %0d, predicted %0d", got, want));
			end
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid;
	logic                  in_stall;
	logic                  operation;
	logic [6:0]            set_index;
	logic [3:0]            way_index;
	logic                  hit;
	logic                  is_instruction;
	logic [PAGE_W-1:0]     page_number;
	logic                  out_valid;
	logic                  out_stall;
	logic [3:0]            victim_way;

	victim_scoreboard  sb;
	bit                tx_idle;
	bit                rx_idle;
	bit                hold_req;
	int                quiet_cycles;
	logic [PAGE_W-1:0] hot_page;
	logic [PAGE_W-1:0] page_pool [4];
	logic [6:0]        set_pool [6];

	translation_rrip_replacement DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.set_index(set_index),
		.way_index(way_index),
		.hit(hit),
		.is_instruction(is_instruction),
		.page_number(page_number),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.victim_way(victim_way)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial sb = new();

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_word(operation, set_index, way_index, hit, is_instruction,
					page_number);
			if (out_valid && !out_stall)
				sb.check_word(victim_way);
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
			(psel && penable && pwrite && pready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin : receiver
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (rx_idle && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 18) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [RRPV_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= APB_DATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_register(idx, val);
	endtask

	task automatic load_settings(input logic [RRPV_W-1:0] max_v,
		input logic [RRPV_W-1:0] instr_v, input logic [RRPV_W-1:0] data_v);
		reg_write(REG_MAX_RRPV, max_v);
		reg_write(REG_INSTR_POS, instr_v);
		reg_write(REG_DATA_POS, data_v);
	endtask

	task automatic send_word(input access_t a);
		if (tx_idle && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid       <= 1'b1;
		operation      <= a.op;
		set_index      <= a.set;
		way_index      <= a.way;
		hit            <= a.hit;
		is_instruction <= a.instr;
		page_number    <= a.page;
		do @(posedge clk); while (in_stall);
	endtask

	// drop valid at the accepting edge, then wait out every victim and the pipeline
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_victims.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic access_t mk(input logic op, input int set, input int way,
		input logic h, input logic instr, input logic [PAGE_W-1:0] page);
		access_t a;
		a.op    = op;
		a.set   = 7'(set);
		a.way   = 4'(way);
		a.hit   = h;
		a.instr = instr;
		a.page  = page;
		return a;
	endfunction

	function automatic access_t random_access();
		access_t a;
		int      r;
		a.op    = ($urandom_range(0, 3) == 0) ? OP_VICTIM : OP_UPDATE;
		a.set   = ($urandom_range(0, 3) != 0) ? set_pool[$urandom_range(0, 5)]
			: 7'($urandom_range(0, 127));
		a.way   = 4'($urandom_range(0, 15));
		a.hit   = 1'($urandom_range(0, 1));
		a.instr = 1'($urandom_range(0, 1));
		r = $urandom_range(0, 19);
		if (r < 8)       a.page = hot_page;
		else if (r < 16) a.page = page_pool[r % 4];
		else             a.page = PAGE_W'({$urandom, $urandom});
		return a;
	endfunction

	initial begin
		arst_n         <= 1'b0;
		psel           <= 1'b0;
		penable        <= 1'b0;
		pwrite         <= 1'b0;
		paddr          <= '0;
		pwdata         <= '0;
		in_valid       <= 1'b0;
		operation      <= OP_UPDATE;
		set_index      <= '0;
		way_index      <= '0;
		hit            <= 1'b0;
		is_instruction <= 1'b0;
		page_number    <= '0;
		tx_idle      = 1'b0;
		rx_idle      = 1'b0;
		hold_req     = 1'b0;
		quiet_cycles = 0;

		hot_page     = PAGE_W'({$urandom, $urandom});
		page_pool[0] = PAGE_W'({$urandom, $urandom});
		page_pool[1] = page_pool[0] ^ (PAGE_W'(1) << PT_W);
		page_pool[2] = PAGE_W'({$urandom, $urandom});
		page_pool[3] = PAGE_W'({$urandom, $urandom});
		set_pool     = '{7'd0, 7'd127, 7'd1, 7'($urandom_range(2, 126)),
			7'($urandom_range(2, 126)), 7'($urandom_range(2, 126))};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		send_word(mk(OP_VICTIM, 0, 0, 0, 0, '0));
		send_word(mk(OP_UPDATE, 0, 15, 1, 0, '0));
		send_word(mk(OP_UPDATE, 0, 3, 0, 0, '1));
		send_word(mk(OP_VICTIM, 0, 15, 1, 1, '1));
		send_word(mk(OP_UPDATE, 127, 15, 0, 1, '1));
		send_word(mk(OP_UPDATE, 127, 0, 1, 1, '1));
		send_word(mk(OP_UPDATE, 127, 5, 0, 1, PAGE_W'(PT_LAST)));
		send_word(mk(OP_UPDATE, 127, 6, 1, 1, '1));
		send_word(mk(OP_VICTIM, 127, 0, 0, 0, '0));
		send_word(mk(OP_UPDATE, 1, 7, 1, 0, 52'h5_5555_5555_5555));
		send_word(mk(OP_UPDATE, 64, 8, 0, 1, 52'hA_AAAA_AAAA_AAAA));
		send_word(mk(OP_UPDATE, 64, int'(WAY_LAST), 1, 1, 52'hA_AAAA_AAAA_AAAA));
		send_word(mk(OP_VICTIM, 64, 3, 1, 0, 52'h5_5555_5555_5555));
		send_word(mk(OP_VICTIM, 1, 9, 0, 1, '0));
		send_word(mk(OP_VICTIM, 127, 15, 1, 1, '1));

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				drain();
				case (ph)
					1: load_settings(4'd15, 4'd0, 4'd0);
					2: load_settings(4'd1, 4'd15, 4'd15);
					4: load_settings(4'd15, 4'd15, 4'd0);
					default: load_settings(4'($urandom_range(1, 15)),
						4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
				endcase
			end
			tx_idle = (ph != 3) && (ph != PHASES - 1);
			rx_idle = tx_idle;
			if (ph == 2) hold_req = 1'b1;
			repeat (PHASE_WORDS) send_word(random_access());
		end

		drain();
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
